[sv/signed_integer_to_ascii_digits_defines.svh]
// Assertion macros shared by the signed integer to ASCII block
`ifndef SIGNED_INTEGER_TO_ASCII_DIGITS_DEFINES_SVH
`define SIGNED_INTEGER_TO_ASCII_DIGITS_DEFINES_SVH

// same-cycle implication, off during reset
`define SITOA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SITOA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sitoa_pkg.sv]
// Package: widths, characters, states and helpers for the integer to ASCII block
`default_nettype none

package sitoa_pkg;

    localparam int VALUE_BITS = 32;
    // decimal digits needed for VALUE_BITS unsigned bits (log10(2) ~ 0.30103)
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DIG_W      = DEC_DIGITS * 4;
    localparam int IDX_W      = (DEC_DIGITS > 1) ? $clog2(DEC_DIGITS) : 1;
    localparam int CNT_W      = $clog2(VALUE_BITS);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ALPHA = 8'h61;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_HEX = 1'b1;

    typedef logic [DEC_DIGITS-1:0][3:0] t_digits;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] w;
        w = {4'b0000, d};
        if (d < 4'd10) begin
            return CH_ZERO + w;
        end
        return CH_ALPHA + w - 8'd10;
    endfunction

endpackage

`default_nettype wire

[sv/sitoa_if.sv]
// Valid/ready channel interfaces for the input numbers and the output characters
`default_nettype none

interface sitoa_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sitoa_pkg::VALUE_BITS-1:0] value;
    logic                               mode;

    modport source (output valid, output value, output mode, input ready);
    modport sink   (input valid, input value, input mode, output ready);
endinterface

interface sitoa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

[sv/sitoa_dabble.sv]
// One double-dabble step: add 3 to each BCD digit above 4, then shift in one bit
`default_nettype none

module sitoa_dabble (
    input  wire sitoa_pkg::t_digits i_dig,
    input  wire                     i_bit,
    output sitoa_pkg::t_digits      o_dig
);

    sitoa_pkg::t_digits            w_adj;
    logic [sitoa_pkg::DIG_W-1:0]   w_flat;

    always_comb begin
        for (int i = 0; i < sitoa_pkg::DEC_DIGITS; i++) begin
            w_adj[i] = (i_dig[i] >= 4'd5) ? i_dig[i] + 4'd3 : i_dig[i];
        end
        w_flat = w_adj;
        // top bit of the top digit falls off; it is never set for VALUE_BITS magnitudes
        o_dig  = {w_flat[sitoa_pkg::DIG_W-2:0], i_bit};
    end

endmodule

`default_nettype wire

[sv/signed_integer_to_ascii_digits.sv]
// Decimal: the number is accepted, converted by 32 double-dabble steps, then leading
// zeros are skipped (the ones digit is always kept) and each character is emitted.
// Hex: the number is accepted, leading zero nibbles are skipped and each character is emitted.
// A negative number emits a minus sign before its digits; sink stalls hold the emission.
// One number at a time: the input is not ready until the last character is taken.
// Reset (synchronous, active low) returns the sequencer to idle, ready for a number.
`default_nettype none

module signed_integer_to_ascii_digits (
    input  wire              i_clk,
    input  wire              i_rst_n,
    sitoa_in_if.sink         i_in,
    sitoa_out_if.source      o_out
);

    localparam int VB = sitoa_pkg::VALUE_BITS;

    sitoa_pkg::t_state             r_state, n_state;
    sitoa_pkg::t_digits            r_dig,   n_dig;
    logic [VB-1:0]                 r_mag,   n_mag;
    logic                          r_neg,   n_neg;
    logic [sitoa_pkg::CNT_W-1:0]   r_cnt,   n_cnt;
    logic [sitoa_pkg::IDX_W-1:0]   r_idx,   n_idx;

    logic [VB-1:0]                 w_in_mag;
    sitoa_pkg::t_digits            w_dab;
    logic                          w_in_take;
    logic                          w_out_take;

    // magnitude fits VB unsigned bits, most negative value included
    assign w_in_mag = i_in.value[VB-1] ? (~i_in.value + VB'(1)) : i_in.value;

    sitoa_dabble u_dabble (
        .i_dig (r_dig),
        .i_bit (r_mag[VB-1]),
        .o_dig (w_dab)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitoa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_dig <= n_dig;
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_idx <= n_idx;
    end

    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        unique case (r_state)
            sitoa_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_neg = i_in.value[VB-1];
                    n_mag = w_in_mag;
                    n_idx = sitoa_pkg::IDX_W'(sitoa_pkg::DEC_DIGITS - 1);
                    if (i_in.mode == sitoa_pkg::MODE_HEX) begin
                        // nibbles are the hex digits already
                        n_dig   = sitoa_pkg::DIG_W'(w_in_mag);
                        n_state = sitoa_pkg::S_SKIP;
                    end else begin
                        n_dig   = '0;
                        n_cnt   = sitoa_pkg::CNT_W'(VB - 1);
                        n_state = sitoa_pkg::S_CONV;
                    end
                end
            end
            sitoa_pkg::S_CONV: begin
                n_dig = w_dab;
                n_mag = {r_mag[VB-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = sitoa_pkg::S_SKIP;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            sitoa_pkg::S_SKIP: begin
                // drop leading zeros, keep at least the ones digit
                if (r_idx != '0 && r_dig[r_idx] == 4'd0) begin
                    n_idx = r_idx - 1'b1;
                end else begin
                    n_state = r_neg ? sitoa_pkg::S_SIGN : sitoa_pkg::S_EMIT;
                end
            end
            sitoa_pkg::S_SIGN: begin
                if (o_out.ready) begin
                    n_state = sitoa_pkg::S_EMIT;
                end
            end
            sitoa_pkg::S_EMIT: begin
                if (o_out.ready) begin
                    if (r_idx == '0) begin
                        n_state = sitoa_pkg::S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = sitoa_pkg::S_IDLE;
            end
        endcase
    end

    assign i_in.ready      = (r_state == sitoa_pkg::S_IDLE);
    assign o_out.valid     = (r_state == sitoa_pkg::S_SIGN) || (r_state == sitoa_pkg::S_EMIT);
    assign o_out.character = (r_state == sitoa_pkg::S_SIGN) ? sitoa_pkg::CH_MINUS
                                                            : sitoa_pkg::digit_char(r_dig[r_idx]);
    assign o_out.last      = (r_state == sitoa_pkg::S_EMIT) && (r_idx == '0);

    assign w_in_take  = i_in.valid && i_in.ready;
    assign w_out_take = o_out.valid && o_out.ready;

`include "signed_integer_to_ascii_digits_defines.svh"

    `SITOA_ASSERT_NOW(a_no_overlap, o_out.valid, !i_in.ready, "input taken while emitting")
    `SITOA_ASSERT_NEXT(a_busy_after_accept, w_in_take, !o_out.valid && !i_in.ready, "idle after accept")
    `SITOA_ASSERT_NEXT(a_idle_after_last, w_out_take && o_out.last, i_in.ready, "busy after last item")
    `SITOA_ASSERT_NOW(a_last_is_digit, o_out.valid && o_out.last, o_out.character != sitoa_pkg::CH_MINUS, "sign marked last")

endmodule

`default_nettype wire

[verif/testbench.sv]
// Testbench for signed_integer_to_ascii_digits: directed rows, random numbers, char checks
`timescale 1ns / 1ps

module testbench;

    localparam int VB           = sitoa_pkg::VALUE_BITS;
    localparam int RANDOM_ITEMS = 157;
    localparam int MAX_GAP      = 6;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_char_item;

    typedef struct {
        logic [VB-1:0] value;
        logic          mode;
        string         text;   // empty: expectation comes from the predictor
    } t_number_row;

    logic clk;
    logic rst_n;

    sitoa_in_if  in_ch ();
    sitoa_out_if out_ch ();

    signed_integer_to_ascii_digits dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_char_item  expected_chars[$];
    t_number_row number_rows[$];

    int error_count   = 0;
    int reported      = 0;
    int numbers_sent  = 0;
    int negative_sent = 0;
    int hex_sent      = 0;
    int chars_checked = 0;
    int cycle_count   = 0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.value  <= '0;
        in_ch.mode   <= sitoa_pkg::MODE_DEC;
        out_ch.ready <= 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sign-magnitude formatting, magnitude one bit wider so the most negative value works
    function automatic void predict_number_chars(logic [VB-1:0] value, logic mode);
        logic [VB:0]  magnitude;
        logic [VB:0]  radix;
        logic [VB:0]  rem;
        logic [7:0]   digits[$];
        t_char_item   item;
        radix     = (mode == sitoa_pkg::MODE_HEX) ? (VB+1)'(16) : (VB+1)'(10);
        magnitude = value[VB-1] ? ({(VB+1){1'b0}} - {value[VB-1], value})
                                : {1'b0, value};
        do begin
            rem = magnitude % radix;
            digits.push_front(rem < 10 ? sitoa_pkg::CH_ZERO + 8'(rem)
                                       : sitoa_pkg::CH_ALPHA + 8'(rem) - 8'd10);
            magnitude = magnitude / radix;
        end while (magnitude != 0);
        if (value[VB-1]) begin
            item.character = sitoa_pkg::CH_MINUS;
            item.last      = 1'b0;
            expected_chars.push_back(item);
        end
        foreach (digits[i]) begin
            item.character = digits[i];
            item.last      = (i == digits.size() - 1);
            expected_chars.push_back(item);
        end
    endfunction

    function automatic void add_row(logic [VB-1:0] value, logic mode, string text);
        t_number_row row;
        row.value = value;
        row.mode  = mode;
        row.text  = text;
        number_rows.push_back(row);
    endfunction

    function automatic logic [VB-1:0] random_value();
        logic [VB-1:0] v;
        int            k;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 999);
            2: v = -$urandom_range(1, 999);
            3: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                        : 32'h7fff_ffff - $urandom_range(0, 3);
            4: begin
                v = 1;
                k = $urandom_range(0, 9);
                repeat (k) v = $urandom_range(0, 1) ? v * 10 : v * 16;
                v = v + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1)) v = -v;
            end
            default: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    // Drive one number, then wait for it to be taken
    task automatic send_number(t_number_row row, bit no_idle);
        int         gap;
        t_char_item item;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= row.value;
        in_ch.mode  <= row.mode;
        do @(posedge clk); while (!in_ch.ready);
        if (row.text.len() > 0) begin
            for (int i = 0; i < row.text.len(); i++) begin
                item.character = row.text[i];
                item.last      = (i == row.text.len() - 1);
                expected_chars.push_back(item);
            end
        end else begin
            predict_number_chars(row.value, row.mode);
        end
        numbers_sent++;
        if (row.value[VB-1]) negative_sent++;
        if (row.mode == sitoa_pkg::MODE_HEX) hex_sent++;
    endtask

    // Character sink: compare against the oldest expectation, stall at random
    initial begin
        int         stall_left;
        bit         took;
        t_char_item seen;
        t_char_item want;
        stall_left = 0;
        forever begin
            @(posedge clk);
            took = rst_n && out_ch.valid && out_ch.ready;
            if (took) begin
                seen.character = out_ch.character;
                seen.last      = out_ch.last;
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    error_count++;
                    if (reported < REPORT_MAX) begin
                        reported++;
                        $display("unexpected char 0x%02h last=%0b", seen.character, seen.last);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    if (seen.character !== want.character || seen.last !== want.last) begin
                        error_count++;
                        if (reported < REPORT_MAX) begin
                            reported++;
                            $display("mismatch: expected char 0x%02h last=%0b, got 0x%02h last=%0b",
                                     want.character, want.last, seen.character, seen.last);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) out_ch.ready <= 1'b1;
            end else if (took) begin
                // every fourth run of 40 chars goes without stalls
                stall_left = ((chars_checked / 40) % 4 == 2) ? 0 : $urandom_range(0, MAX_GAP);
                if (stall_left > 0) out_ch.ready <= 1'b0;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin
        t_number_row row;
        add_row(32'h0000_0000, sitoa_pkg::MODE_DEC, "0");
        add_row(32'h0000_0000, sitoa_pkg::MODE_HEX, "0");
        add_row(32'h7fff_ffff, sitoa_pkg::MODE_DEC, "2147483647");
        add_row(32'h7fff_ffff, sitoa_pkg::MODE_HEX, "7fffffff");
        add_row(32'h8000_0000, sitoa_pkg::MODE_DEC, "-2147483648");
        add_row(32'h8000_0000, sitoa_pkg::MODE_HEX, "-80000000");
        add_row(32'hffff_ffff, sitoa_pkg::MODE_DEC, "-1");
        add_row(32'hffff_ffff, sitoa_pkg::MODE_HEX, "-1");
        add_row(32'd1,         sitoa_pkg::MODE_DEC, "1");
        add_row(32'd9,         sitoa_pkg::MODE_DEC, "9");
        add_row(32'd10,        sitoa_pkg::MODE_DEC, "10");
        add_row(32'd15,        sitoa_pkg::MODE_HEX, "f");
        add_row(32'd16,        sitoa_pkg::MODE_HEX, "10");
        add_row(-32'sd255,     sitoa_pkg::MODE_HEX, "-ff");
        add_row(-32'sd10,      sitoa_pkg::MODE_DEC, "-10");
        add_row(32'd1000000000, sitoa_pkg::MODE_DEC, "");
        add_row(32'd999999999,  sitoa_pkg::MODE_DEC, "");
        add_row(32'h8000_0001, sitoa_pkg::MODE_DEC, "");
        add_row(32'habcd_ef01, sitoa_pkg::MODE_HEX, "");
        add_row(32'h1234_5678, sitoa_pkg::MODE_HEX, "");
        add_row(32'h5555_5555, sitoa_pkg::MODE_DEC, "");
        add_row(32'haaaa_aaaa, sitoa_pkg::MODE_HEX, "");
        add_row(32'h0fed_cba9, sitoa_pkg::MODE_HEX, "");

        while (rst_n !== 1'b1) @(posedge clk);

        foreach (number_rows[i]) send_number(number_rows[i], i % 8 < 3);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            row.value = random_value();
            row.mode  = 1'($urandom_range(0, 1));
            row.text  = "";
            // every fourth run of 30 numbers goes back to back
            send_number(row, (n / 30) % 4 == 3);
        end
        in_ch.valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d numbers (%0d negative, %0d hex) and %0d characters",
                 numbers_sent, negative_sent, hex_sent, chars_checked);
        $display("%0d errors in %0d cycles", error_count, cycle_count);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/sitoa_pkg.sv
sv/sitoa_if.sv
sv/sitoa_dabble.sv
sv/signed_integer_to_ascii_digits.sv
verif/testbench.sv
